// ----- design/fwpe_pkg.sv -----
// fwpe_pkg: types and constants shared by the fixed width pack encoder
// used by fwpe_collect, fwpe_packer and fixed_width_pack_encoder
package fwpe_pkg;

  localparam int MAX_COUNT   = 16;
  localparam int HEADER_BITS = 6;
  localparam int IDX_W       = $clog2(MAX_COUNT);
  localparam int COUNT_W     = $clog2(MAX_COUNT + 1);
  localparam int LEN_W       = 6;   // significant length 0..32
  localparam int FILL_W      = 6;   // packer fill 0..63
  localparam int TOTAL_W     = 10;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_ALIGNED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_BYTES  = 2'd1;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } in_t;

  typedef struct packed {
    logic [31:0]        word;
    logic [2:0]         bytes_valid;
    logic               end_of_block;
    logic [TOTAL_W-1:0] total_bits;
  } out_t;

  // collector status toward the sequencer
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [LEN_W-1:0]   sig_len;
  } col_stat_t;

  // packer command from the sequencer
  typedef struct packed {
    logic              clear;
    logic              append;
    logic              pop;
    logic [31:0]       chunk;
    logic [LEN_W-1:0]  width;
  } pk_ctrl_t;

  typedef struct packed {
    logic [31:0]       word;
    logic [FILL_W-1:0] fill;
  } pk_stat_t;

endpackage

// ----- design/fixed_width_pack_encoder.sv -----
// fixed_width_pack_encoder: top level with sequencer, config registers and output register
// depends on fwpe_pkg, fwpe_collect and fwpe_packer
//
// Values are taken one per cycle while the encoder is idle and stored (up to 16 per
// block); the item marked last, or the one that fills the store, starts encoding and
// the block is not ready until the final word of the block is loaded into the output
// register. Encoding runs through one shared shift-and-or packer: it finds the bit
// length, appends the header, then appends each value (none when the length is zero),
// and pops each output word, with any output stall holding it. byte_aligned is read
// when the header is appended; value_bytes applies to each value as it arrives.
module fixed_width_pack_encoder import fwpe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_LEN, S_HDR, S_VAL, S_OUT} state_t;

  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [LEN_W-1:0]   wid_r, wid_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               done_r, done_nxt;
  logic               byte_aligned_r;
  logic [2:0]         value_bytes_r;

  logic               col_wr, col_clear;
  logic [31:0]        col_rd_value;
  col_stat_t          col_stat;
  pk_ctrl_t           pk_ctrl;
  pk_stat_t           pk_stat;
  logic [2:0]         cw;
  logic [FILL_W-1:0]  fill_sum;
  logic [IDX_W-1:0]   last_idx;
  logic               out_load, end_word;

  fwpe_collect u_collect (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr_en       (col_wr),
    .wr_value    (in_data.value),
    .value_bytes (value_bytes_r),
    .clear       (col_clear),
    .rd_idx      (rd_idx_r),
    .rd_value    (col_rd_value),
    .stat        (col_stat)
  );

  fwpe_packer u_packer (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (pk_ctrl),
    .stat  (pk_stat)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_aligned_r <= 1'b0;
      value_bytes_r  <= 3'd4;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BYTE_ALIGNED: byte_aligned_r <= cfg_data[0];
        CFG_VALUE_BYTES:  value_bytes_r  <= cfg_data;
        default:          ;
      endcase
    end
  end

  assign cw       = 3'(({1'b0, len_r} + 7'd7) >> 3);
  assign fill_sum = pk_stat.fill + wid_r;
  assign last_idx = IDX_W'(col_stat.count - COUNT_W'(1));
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign end_word = done_r && (pk_stat.fill <= FILL_W'(32));

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    len_nxt       = len_r;
    wid_nxt       = wid_r;
    total_nxt     = total_r;
    rd_idx_nxt    = rd_idx_r;
    done_nxt      = done_r;
    col_wr        = 1'b0;
    col_clear     = 1'b0;
    pk_ctrl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          col_wr = 1'b1;
          if (in_data.last || col_stat.count == COUNT_W'(MAX_COUNT - 1)) begin
            state_nxt = S_LEN;
          end
        end
      end
      S_LEN: begin
        len_nxt   = col_stat.sig_len;
        state_nxt = S_HDR;
      end
      S_HDR: begin
        pk_ctrl.append = 1'b1;
        rd_idx_nxt     = '0;
        if (byte_aligned_r) begin
          pk_ctrl.chunk = 32'(cw);
          pk_ctrl.width = LEN_W'(8);
          wid_nxt       = {cw, 3'b000};
          total_nxt     = TOTAL_W'({(TOTAL_W - 3)'(col_stat.count) * (TOTAL_W - 3)'(cw)
                                    + 7'd1, 3'b000});
        end else begin
          pk_ctrl.chunk = 32'(len_r);
          pk_ctrl.width = LEN_W'(HEADER_BITS);
          wid_nxt       = len_r;
          total_nxt     = TOTAL_W'(HEADER_BITS) + TOTAL_W'(col_stat.count) * TOTAL_W'(len_r);
        end
        if (wid_nxt == '0) begin
          done_nxt  = 1'b1;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_VAL;
        end
      end
      S_VAL: begin
        pk_ctrl.append = 1'b1;
        pk_ctrl.chunk  = col_rd_value;
        pk_ctrl.width  = wid_r;
        rd_idx_nxt     = rd_idx_r + IDX_W'(1);
        if (rd_idx_r == last_idx) begin
          done_nxt  = 1'b1;
          state_nxt = S_OUT;
        end else if (fill_sum[5]) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.word         = pk_stat.word;
          out_data_nxt.end_of_block = end_word;
          out_data_nxt.total_bits   = total_r;
          if (pk_stat.fill >= FILL_W'(32)) begin
            out_data_nxt.bytes_valid = 3'd4;
          end else begin
            out_data_nxt.bytes_valid = 3'((pk_stat.fill + FILL_W'(7)) >> 3);
          end
          if (end_word) begin
            pk_ctrl.clear = 1'b1;
            col_clear     = 1'b1;
            done_nxt      = 1'b0;
            state_nxt     = S_IDLE;
          end else begin
            pk_ctrl.pop = 1'b1;
            if (!done_r) state_nxt = S_VAL;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      done_r      <= done_nxt;
    end
    out_data_r <= out_data_nxt;
    len_r      <= len_nxt;
    wid_r      <= wid_nxt;
    total_r    <= total_nxt;
    rd_idx_r   <= rd_idx_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // packer must be empty between blocks
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (pk_stat.fill == '0))
    else $error("packer not empty while idle");

  // a value is only appended while less than a word is pending
  a_val_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_VAL) |-> (pk_stat.fill < FILL_W'(32)))
    else $error("packer overfull before append");

  // every shown word carries at least one byte
  a_bytes_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.bytes_valid >= 3'd1 && out_data_r.bytes_valid <= 3'd4))
    else $error("bad bytes_valid");

  // the final word returns the block to idle
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && end_word) |=> (state_r == S_IDLE && out_data_r.end_of_block))
    else $error("end of block did not return to idle");

endmodule

// ----- design/fwpe_collect.sv -----
// fwpe_collect: value store, item count and running OR of the current block
// depends on fwpe_pkg
module fwpe_collect import fwpe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [31:0]      wr_value,
  input  logic [2:0]       value_bytes,
  input  logic             clear,
  input  logic [IDX_W-1:0] rd_idx,
  output logic [31:0]      rd_value,
  output col_stat_t        stat
);

  logic [31:0]        store_r [MAX_COUNT];
  logic [COUNT_W-1:0] count_r;
  logic [31:0]        or_r;
  logic [31:0]        masked;
  logic [LEN_W-1:0]   len;

  always_comb begin
    case (value_bytes)
      3'd0, 3'd1: masked = {24'd0, wr_value[7:0]};
      3'd2:       masked = {16'd0, wr_value[15:0]};
      3'd3:       masked = {8'd0, wr_value[23:0]};
      default:    masked = wr_value;
    endcase
  end

  // largest significant length equals the length of the OR of all values
  always_comb begin
    len = '0;
    for (int i = 0; i < 32; i++) begin
      if (or_r[i]) len = LEN_W'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[count_r[IDX_W-1:0]] <= masked;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      count_r <= '0;
      or_r    <= '0;
    end else if (wr_en) begin
      count_r <= count_r + COUNT_W'(1);
      or_r    <= or_r | masked;
    end
  end

  assign rd_value     = store_r[rd_idx];
  assign stat.count   = count_r;
  assign stat.sig_len = len;

endmodule

// ----- design/fwpe_packer.sv -----
// fwpe_packer: bit accumulator that appends chunks lsb first and pops 32-bit words
// depends on fwpe_pkg
module fwpe_packer import fwpe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  pk_ctrl_t ctrl,
  output pk_stat_t stat
);

  logic [63:0]       acc_r;
  logic [FILL_W-1:0] fill_r;
  logic [63:0]       shifted;

  // bits above fill are always zero, so an OR places the new chunk
  assign shifted = {32'd0, ctrl.chunk} << fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      acc_r  <= '0;
      fill_r <= '0;
    end else if (ctrl.append) begin
      acc_r  <= acc_r | shifted;
      fill_r <= fill_r + ctrl.width;
    end else if (ctrl.pop) begin
      acc_r  <= {32'd0, acc_r[63:32]};
      fill_r <= fill_r - FILL_W'(32);
    end
  end

  assign stat.word = acc_r[31:0];
  assign stat.fill = fill_r;

endmodule
